[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge, skipped while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on each rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mrtu_pkg.sv]
// Types, constants and the CRC step for the Modbus RTU frame receiver.
`default_nettype none
package mrtu_pkg;

  localparam logic [15:0] CRC_START      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  EXC_FLAG       = 8'h80;
  localparam logic [7:0]  WRITE_FUNC     = 8'd6;
  localparam logic [7:0]  ILLEGAL_FUNC   = 8'd1;
  localparam logic [7:0]  MIN_FRAME      = 8'd4;
  localparam logic [7:0]  MIN_WRITE      = 8'd8;
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd101;
  localparam logic [7:0]  TRIGGER_RST    = 8'd25;
  localparam logic [7:0]  BYTES_MAX      = 8'd255;
  localparam logic [7:0]  IDX_ADDR       = 8'd0;
  localparam logic [7:0]  IDX_FUNC       = 8'd1;
  localparam logic [7:0]  IDX_FIRST_CRC  = 8'd2;
  localparam logic [7:0]  IDX_SIXTH      = 8'd5;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDRESS = 1'b0,
    CFG_TRIGGER_VALUE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_REPLY   = 1'b0,
    KIND_TRIGGER = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    POS_ADDR   = 3'd0,
    POS_FUNC   = 3'd1,
    POS_CODE   = 3'd2,
    POS_CRC_LO = 3'd3,
    POS_CRC_HI = 3'd4
  } rpos_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] trigger_value;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] addr;
    logic [7:0] func_x;
  } evt_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/mrtu_frame_parser.sv]
// Frame parser: CRC, byte capture and frame-end decision.
`default_nettype none
module mrtu_frame_parser (
  input  logic              clk,
  input  logic              rst,
  input  mrtu_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  output logic              evt_valid,
  input  logic              evt_ready,
  output mrtu_pkg::evt_t    evt
);

  logic [15:0] crc, crc_next;
  logic [7:0]  d0, d0_next;
  logic [7:0]  d1, d1_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  func_code, func_code_next;
  logic [7:0]  sixth_byte, sixth_byte_next;
  logic [15:0] crc_fed;
  logic [7:0]  cap_first, cap_func, cap_sixth, len;
  logic        frame_ok, evt_new, in_fire;
  mrtu_pkg::evt_t evt_next;

  assign in_ready = !evt_valid || evt_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    crc_fed   = (bytes_seen >= mrtu_pkg::IDX_FIRST_CRC) ?
                mrtu_pkg::crc_feed(crc, d0) : crc;
    cap_first = (bytes_seen == mrtu_pkg::IDX_ADDR)  ? rx_byte : first_byte;
    cap_func  = (bytes_seen == mrtu_pkg::IDX_FUNC)  ? rx_byte : func_code;
    cap_sixth = (bytes_seen == mrtu_pkg::IDX_SIXTH) ? rx_byte : sixth_byte;
    len       = (bytes_seen == mrtu_pkg::BYTES_MAX) ? bytes_seen : bytes_seen + 8'd1;
    frame_ok  = (len >= mrtu_pkg::MIN_FRAME) &&
                (cap_first == cfg.slave_address) &&
                (crc_fed[7:0] == d1) && (crc_fed[15:8] == rx_byte);

    evt_new         = 1'b0;
    evt_next.kind   = mrtu_pkg::KIND_REPLY;
    evt_next.addr   = cap_first;
    evt_next.func_x = cap_func + mrtu_pkg::EXC_FLAG;
    if (frame_end && frame_ok) begin
      if (cap_func == mrtu_pkg::WRITE_FUNC) begin
        evt_next.kind = mrtu_pkg::KIND_TRIGGER;
        evt_new = (len >= mrtu_pkg::MIN_WRITE) && (cap_sixth == cfg.trigger_value);
      end else begin
        evt_new = 1'b1;
      end
    end

    if (frame_end) begin
      crc_next        = mrtu_pkg::CRC_START;
      d0_next         = 8'd0;
      d1_next         = 8'd0;
      bytes_seen_next = 8'd0;
      first_byte_next = 8'd0;
      func_code_next  = 8'd0;
      sixth_byte_next = 8'd0;
    end else begin
      crc_next        = crc_fed;
      d0_next         = d1;
      d1_next         = rx_byte;
      bytes_seen_next = len;
      first_byte_next = cap_first;
      func_code_next  = cap_func;
      sixth_byte_next = cap_sixth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= mrtu_pkg::CRC_START;
      d0         <= 8'd0;
      d1         <= 8'd0;
      bytes_seen <= 8'd0;
      first_byte <= 8'd0;
      func_code  <= 8'd0;
      sixth_byte <= 8'd0;
      evt_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        crc        <= crc_next;
        d0         <= d0_next;
        d1         <= d1_next;
        bytes_seen <= bytes_seen_next;
        first_byte <= first_byte_next;
        func_code  <= func_code_next;
        sixth_byte <= sixth_byte_next;
      end
      if (evt_valid && evt_ready) begin
        evt_valid <= 1'b0;
      end
      if (in_fire && evt_new) begin
        evt_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && evt_new) begin
      evt <= evt_next;
    end
  end

endmodule
`default_nettype wire

[design/mrtu_reply_gen.sv]
// Reply sequencer and output register.
`default_nettype none
module mrtu_reply_gen (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  output logic              evt_ready,
  input  mrtu_pkg::evt_t    evt,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        tx_byte,
  output logic              reply_last
);

  logic                  seq_busy;
  mrtu_pkg::rpos_t       seq_pos;
  mrtu_pkg::kind_t       seq_kind;
  logic [7:0]            r_addr, r_func;
  logic [15:0]           r_crc;
  logic [7:0]            item_byte;
  logic                  item_last, advance;

  assign evt_ready = !seq_busy;
  assign advance   = !out_valid || out_ready;

  always_comb begin
    item_last = 1'b0;
    case (seq_pos)
      mrtu_pkg::POS_ADDR:   item_byte = r_addr;
      mrtu_pkg::POS_FUNC:   item_byte = r_func;
      mrtu_pkg::POS_CODE:   item_byte = mrtu_pkg::ILLEGAL_FUNC;
      mrtu_pkg::POS_CRC_LO: item_byte = r_crc[7:0];
      mrtu_pkg::POS_CRC_HI: begin
        item_byte = r_crc[15:8];
        item_last = 1'b1;
      end
      default:              item_byte = 8'd0;
    endcase
    if (seq_kind == mrtu_pkg::KIND_TRIGGER) begin
      item_byte = 8'd0;
      item_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= seq_busy;
        if (seq_busy) begin
          if (item_last) begin
            seq_busy <= 1'b0;
          end
        end
      end
      if (evt_valid && evt_ready) begin
        seq_busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && seq_busy) begin
      out_kind   <= seq_kind;
      tx_byte    <= item_byte;
      reply_last <= item_last;
      seq_pos    <= mrtu_pkg::rpos_t'(seq_pos + 3'd1);
      if (seq_pos == mrtu_pkg::POS_ADDR || seq_pos == mrtu_pkg::POS_FUNC ||
          seq_pos == mrtu_pkg::POS_CODE) begin
        r_crc <= mrtu_pkg::crc_feed(r_crc, item_byte);
      end
    end
    if (evt_valid && evt_ready) begin
      seq_pos  <= mrtu_pkg::POS_ADDR;
      seq_kind <= evt.kind;
      r_addr   <= evt.addr;
      r_func   <= evt.func_x;
      r_crc    <= mrtu_pkg::CRC_START;
    end
  end

endmodule
`default_nettype wire

[design/modbus_rtu_frame_receiver.sv]
// Modbus RTU frame receiver: checks address and CRC, emits trigger or exception reply.
// Throughput: one frame byte per cycle while in_ready is high; one reply byte per cycle
// while out_ready is high. The decision is registered when the last frame byte is taken,
// then passes the sequencer and output register; an exception reply is five bytes long.
// Input stalls only while a decided result waits behind a reply still being sent.
// Reset: synchronous, clears frame state and queued results, restores address 101, trigger 25.
`default_nettype none
module modbus_rtu_frame_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrtu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      tx_byte,
  output logic                            reply_last
);

  mrtu_pkg::cfg_t cfg;
  mrtu_pkg::evt_t evt;
  logic           evt_valid, evt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= mrtu_pkg::SLAVE_ADDR_RST;
      cfg.trigger_value <= mrtu_pkg::TRIGGER_RST;
    end else if (cfg_we) begin
      case (mrtu_pkg::cfg_idx_t'(cfg_index))
        mrtu_pkg::CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data;
        mrtu_pkg::CFG_TRIGGER_VALUE: cfg.trigger_value <= cfg_data;
        default: ;
      endcase
    end
  end

  mrtu_frame_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  mrtu_reply_gen u_reply (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .reply_last (reply_last)
  );

endmodule
`default_nettype wire

[design/mrtu_checker.sv]
// Port-level checks for the Modbus RTU frame receiver, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mrtu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] tx_byte,
  input logic       reply_last
);

  `ASSERT_CLK(a_rst_clears_out, clk, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK_RST(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(out_kind) &&
      $stable(reply_last),
    "stalled output changed")
  `ASSERT_CLK_RST(a_trigger_shape, clk, rst,
    out_valid && out_kind |-> tx_byte == 8'd0 && reply_last, "malformed trigger event")
  `ASSERT_CLK_RST(a_reply_continues, clk, rst,
    out_valid && out_ready && !reply_last |=> out_valid && !out_kind, "reply frame broken")

endmodule

bind modbus_rtu_frame_receiver mrtu_checker u_mrtu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_kind   (out_kind),
  .tx_byte    (tx_byte),
  .reply_last (reply_last)
);
`default_nettype wire

[bench/modbus_rtu_frame_receiver_test.sv]
// Self-checking testbench for the Modbus RTU frame receiver.
`timescale 1ns / 100ps

module modbus_rtu_frame_receiver_test;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned LONG_FRAME    = 260;

  typedef struct packed {
    mrtu_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  mrtu_pkg::cfg_idx_t cfg_index;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               frame_end;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [7:0]         tx_byte;
  logic               reply_last;

  logic [15:0] crc_acc;
  logic [7:0]  hold_prev;
  logic [7:0]  hold_last;
  logic [7:0]  frame_len;
  logic [7:0]  seen_addr;
  logic [7:0]  seen_func;
  logic [7:0]  seen_sixth;
  logic [7:0]  station_addr;
  logic [7:0]  trigger_val;

  reply_t      expected_replies[$];
  logic [7:0]  frame_buf[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit          no_idle = 1'b0;

  modbus_rtu_frame_receiver i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .reply_last (reply_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      if (acc[0])
        acc = (acc >> 1) ^ mrtu_pkg::CRC_POLY;
      else
        acc = acc >> 1;
    end
    return acc;
  endfunction

  function automatic void clear_frame_state();
    crc_acc    = mrtu_pkg::CRC_START;
    hold_prev  = 8'h00;
    hold_last  = 8'h00;
    frame_len  = 8'h00;
    seen_addr  = 8'h00;
    seen_func  = 8'h00;
    seen_sixth = 8'h00;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [7:0]  slot;
    logic [7:0]  crc_lo;
    logic [7:0]  crc_hi;
    logic [7:0]  echo_func;
    logic [15:0] reply_crc;
    logic        accepted;
    slot = frame_len;
    if (slot >= mrtu_pkg::IDX_FIRST_CRC)
      crc_acc = crc16_byte(crc_acc, hold_prev);
    if (slot == mrtu_pkg::IDX_ADDR)
      seen_addr = b;
    else if (slot == mrtu_pkg::IDX_FUNC)
      seen_func = b;
    else if (slot == mrtu_pkg::IDX_SIXTH)
      seen_sixth = b;
    crc_lo    = hold_last;
    crc_hi    = b;
    hold_prev = hold_last;
    hold_last = b;
    if (frame_len != mrtu_pkg::BYTES_MAX)
      frame_len = frame_len + 8'd1;
    if (!last)
      return;
    accepted = frame_len >= mrtu_pkg::MIN_FRAME && seen_addr == station_addr &&
               crc_acc == {crc_hi, crc_lo};
    if (accepted) begin
      if (seen_func == mrtu_pkg::WRITE_FUNC) begin
        if (frame_len >= mrtu_pkg::MIN_WRITE && seen_sixth == trigger_val)
          expected_replies.push_back('{kind: mrtu_pkg::KIND_TRIGGER, data: 8'h00,
                                       last: 1'b1});
      end else begin
        echo_func = seen_func + mrtu_pkg::EXC_FLAG;
        reply_crc = crc16_byte(crc16_byte(crc16_byte(mrtu_pkg::CRC_START, station_addr),
                                          echo_func),
                               mrtu_pkg::ILLEGAL_FUNC);
        expected_replies.push_back('{kind: mrtu_pkg::KIND_REPLY, data: station_addr,
                                     last: 1'b0});
        expected_replies.push_back('{kind: mrtu_pkg::KIND_REPLY, data: echo_func,
                                     last: 1'b0});
        expected_replies.push_back('{kind: mrtu_pkg::KIND_REPLY, data: mrtu_pkg::ILLEGAL_FUNC,
                                     last: 1'b0});
        expected_replies.push_back('{kind: mrtu_pkg::KIND_REPLY, data: reply_crc[7:0],
                                     last: 1'b0});
        expected_replies.push_back('{kind: mrtu_pkg::KIND_REPLY, data: reply_crc[15:8],
                                     last: 1'b1});
      end
    end
    clear_frame_state();
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected output kind %0d byte %02h last %0d",
                                  out_kind, tx_byte, reply_last));
      end else begin
        want = expected_replies.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
        if (tx_byte !== want.data)
          report_mismatch($sformatf("tx_byte %02h, want %02h", tx_byte, want.data));
        if (reply_last !== want.last)
          report_mismatch($sformatf("reply_last %0d, want %0d", reply_last, want.last));
      end
    end
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i])
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic build_body(logic [7:0] addr, logic [7:0] func, int unsigned body_len);
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(func);
    while (frame_buf.size() < body_len)
      frame_buf.push_back(8'($urandom));
  endtask

  task automatic append_crc();
    logic [15:0] c;
    c = mrtu_pkg::CRC_START;
    foreach (frame_buf[i])
      c = crc16_byte(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mrtu_pkg::cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mrtu_pkg::CFG_SLAVE_ADDRESS)
      station_addr = value;
    else
      trigger_val = value;
  endtask

  task automatic load_settings(logic [7:0] addr, logic [7:0] trig);
    wait_for_replies();
    write_reg(mrtu_pkg::CFG_SLAVE_ADDRESS, addr);
    write_reg(mrtu_pkg::CFG_TRIGGER_VALUE, trig);
  endtask

  task automatic test_exception_reply();
    frame_buf.delete();
    frame_buf.push_back(station_addr);
    frame_buf.push_back(8'hFF);
    append_crc();
    send_frame();
  endtask

  task automatic test_write_trigger();
    frame_buf.delete();
    frame_buf.push_back(station_addr);
    frame_buf.push_back(mrtu_pkg::WRITE_FUNC);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(trigger_val);
    append_crc();
    send_frame();
  endtask

  task automatic test_short_frames();
    frame_buf.delete();
    frame_buf.push_back(station_addr);
    send_frame();
    frame_buf.delete();
    frame_buf.push_back(station_addr);
    frame_buf.push_back(mrtu_pkg::WRITE_FUNC);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(trigger_val);
    append_crc();
    send_frame();
  endtask

  task automatic test_rejected_frames();
    frame_buf.delete();
    frame_buf.push_back(station_addr ^ 8'h01);
    frame_buf.push_back(8'h03);
    append_crc();
    send_frame();
    frame_buf.delete();
    frame_buf.push_back(station_addr);
    frame_buf.push_back(8'h00);
    append_crc();
    frame_buf[3] = frame_buf[3] ^ 8'h80;
    send_frame();
  endtask

  task automatic test_long_frame();
    wait_for_replies();
    build_body(station_addr, 8'h03, LONG_FRAME - 2);
    append_crc();
    send_frame();
  endtask

  task automatic test_random_traffic(int unsigned item_goal);
    int unsigned goal_end;
    int unsigned pick;
    int unsigned len;
    int unsigned spot;
    logic [7:0]  func;
    goal_end = bytes_sent + item_goal;
    while (bytes_sent < goal_end) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        func = ($urandom_range(0, 2) == 0) ? mrtu_pkg::WRITE_FUNC : 8'($urandom);
        if (func == mrtu_pkg::WRITE_FUNC)
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : 8;
        else
          len = $urandom_range(4, 10);
        build_body(station_addr, func, len - 2);
        if (len >= 8 && $urandom_range(0, 9) < 7)
          frame_buf[mrtu_pkg::IDX_SIXTH] = trigger_val;
        if (pick >= 55 && pick < 65)
          frame_buf[0] = station_addr ^ 8'($urandom_range(1, 255));
        append_crc();
        if (pick >= 65) begin
          spot = $urandom_range(0, frame_buf.size() - 1);
          frame_buf[spot] = frame_buf[spot] ^ 8'(1 << $urandom_range(0, 7));
        end
      end else if (pick < 90) begin
        frame_buf.delete();
        frame_buf.push_back(station_addr);
        repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
      if ($urandom_range(0, 9) == 0)
        wait_for_replies();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_register_settings();
    load_settings(8'h00, 8'h00);
    test_random_traffic(22);
    load_settings(8'hFF, 8'hFF);
    test_random_traffic(22);
    load_settings(8'($urandom), 8'($urandom));
    test_random_traffic(22);
    load_settings(mrtu_pkg::SLAVE_ADDR_RST, 8'($urandom));
    test_random_traffic(22);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = mrtu_pkg::CFG_SLAVE_ADDRESS;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    frame_end    = 1'b0;
    station_addr = mrtu_pkg::SLAVE_ADDR_RST;
    trigger_val  = mrtu_pkg::TRIGGER_RST;
    clear_frame_state();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_exception_reply();
    test_write_trigger();
    test_short_frames();
    test_rejected_frames();
    test_long_frame();
    test_register_settings();

    wait_for_replies();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
